@@ hw/rtl/swmf_pkg.sv @@
package swmf_pkg;
  localparam int WINDOW_DEF   = 10;
  localparam int CHANNELS_DEF = 10;
  localparam int SAMPLE_W     = 16;
  localparam int CHAN_W       = 4;
  localparam int TDATA_W      = 24;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_MEDIAN = 2'd0;
  localparam mode_t MODE_MEAN   = 2'd1;
  localparam mode_t MODE_MODE   = 2'd2;
endpackage

@@ hw/rtl/swmf_ram.sv @@
module swmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/sliding_window_median_mean_mode_filter_top.sv @@
// Per-channel sliding window filter: median, mean or mode of the last WINDOW samples.
// Input beats (in_*) carry a channel number and a signed sample; each accepted beat
// gives exactly one output beat (out_*) with the channel echoed and the filtered value.
// The first sample on a channel fills that channel's whole window.
// cfg_we writes the 2-bit filter mode (0 median, 1 mean, 2 mode, 3 as median); write
// it only while the block is idle.
// A channel out of range answers 0 without a sweep of the window.
// The window memory is read one entry per cycle into an insertion sorter; the mean is
// the window sum times a fixed reciprocal of WINDOW, the mode a scan of the sorted cells.
// One item is in work at a time. in_tready rises again as soon as the result is in the
// output register, so the next item is taken while that result waits for out_tready;
// an item that finishes while the output register is still full waits for it.
// Reset (rst_n low, synchronous) clears the mode register, all window priming and the
// oldest-slot pointers and drops out_tvalid; the window memory needs no clearing.
module sliding_window_median_mean_mode_filter_top
  import swmf_pkg::*;
#(
  parameter int WINDOW   = WINDOW_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [3:0] channel, [19:4] sample
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata   // [3:0] channel_out, [19:4] filtered
);
  localparam int KW    = $clog2(WINDOW);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = $clog2(CHANNELS * WINDOW);
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  // quotient by WINDOW as a multiply by a rounded-up reciprocal, exact over the sum range
  localparam int RECIP_SH = SUM_W + KW;
  localparam int RECIP_W  = SUM_W + 2;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam longint RECIP_L =
    ((longint'(1) << RECIP_SH) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_MODE = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_NEG  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r;
  mode_t      mode_r;

  logic [CHAN_W-1:0]          ch_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       primed_now_r;
  logic [KW-1:0]              slot_r;
  logic [KW-1:0]              k_r;
  logic [KW-1:0]              kd_r;
  logic                       feed_v_r;

  logic [CHANNELS-1:0] primed_r;
  logic [KW-1:0]       oldest_r [CHANNELS];

  logic signed [SAMPLE_W-1:0] cell_r   [WINDOW];
  logic signed [SAMPLE_W-1:0] cell_nxt [WINDOW];
  logic [WINDOW-1:0]          fv_r;
  logic [WINDOW:0]            ge;

  logic signed [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]           mag_r;
  logic [PROD_W-1:0]          quot_prod;
  logic                       neg_r;

  logic signed [SAMPLE_W-1:0] run_val_r;
  logic [CNT_W-1:0]           run_cnt_r;
  logic [CNT_W-1:0]           run_cnt_nxt;
  logic signed [SAMPLE_W-1:0] best_val_r;
  logic signed [SAMPLE_W-1:0] best_val_nxt;
  logic [CNT_W-1:0]           best_cnt_r;
  logic [CNT_W-1:0]           best_cnt_nxt;

  logic signed [SAMPLE_W-1:0] res_r;
  logic                       out_v_r;
  logic [TDATA_W-1:0]         out_d_r;

  logic                       in_acc;
  logic [CHAN_W-1:0]          in_ch;
  logic signed [SAMPLE_W-1:0] in_smp;
  logic                       in_range;
  logic [CHW-1:0]             in_idx;
  logic [CHW-1:0]             cidx;
  logic [AW-1:0]              base;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [AW-1:0]              ram_raddr;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] fval;
  logic                       out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_ch     = in_tdata[CHAN_W-1:0];
  assign in_smp    = in_tdata[CHAN_W+SAMPLE_W-1:CHAN_W];
  assign in_range  = {1'b0, in_ch} < (CHAN_W+1)'(CHANNELS);
  assign in_idx    = in_ch[CHW-1:0];
  assign cidx      = ch_r[CHW-1:0];
  assign out_free  = !out_v_r || out_tready;

  // window memory: read every entry in turn, write the new sample once
  // (or every entry when the channel is being primed)
  assign base      = AW'(cidx) * AW'(WINDOW);
  assign ram_raddr = base + AW'(k_r);
  assign ram_we    = (state_r == S_RUN) && (!primed_now_r || (k_r == '0));
  assign ram_waddr = base + AW'(primed_now_r ? slot_r : k_r);

  swmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CHANNELS * WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (x_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the slot being replaced reads back the new sample, whatever the memory held
  assign fval = (!primed_now_r || (kd_r == slot_r)) ? x_r : $signed(ram_rdata);

  // sorted insertion into the cell row, or a shift down for the mode scan
  always_comb begin
    ge[0] = 1'b1;
    for (int i = 0; i < WINDOW; i++) begin
      ge[i+1] = fv_r[i] && (cell_r[i] <= fval);
    end
    for (int i = 0; i < WINDOW; i++) begin
      if (state_r == S_MODE) begin
        cell_nxt[i] = cell_r[(i == WINDOW-1) ? i : i+1];
      end else if (ge[i+1]) begin
        cell_nxt[i] = cell_r[i];
      end else if (ge[i]) begin
        cell_nxt[i] = fval;
      end else begin
        cell_nxt[i] = cell_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // run-length over the sorted cells; strict compare keeps the smaller value on a tie
  always_comb begin
    if (k_r == '0 || cell_r[0] != run_val_r) begin
      run_cnt_nxt = CNT_W'(1);
    end else begin
      run_cnt_nxt = run_cnt_r + CNT_W'(1);
    end
    if (run_cnt_nxt > best_cnt_r) begin
      best_cnt_nxt = run_cnt_nxt;
      best_val_nxt = cell_r[0];
    end else begin
      best_cnt_nxt = best_cnt_r;
      best_val_nxt = best_val_r;
    end
  end

  assign quot_prod = PROD_W'(mag_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (feed_v_r || state_r == S_MODE) begin
      for (int i = 0; i < WINDOW; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
    if (feed_v_r) begin
      sum_r <= sum_r + SUM_W'(fval);
    end
    if (in_acc) begin
      ch_r  <= in_ch;
      x_r   <= in_smp;
      sum_r <= '0;
    end
    kd_r <= k_r;
    case (state_r)
      S_SEL: begin
        neg_r      <= sum_r[SUM_W-1];
        mag_r      <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
        best_cnt_r <= '0;
        best_val_r <= '0;
        res_r      <= cell_r[WINDOW/2];
      end
      S_MODE: begin
        run_val_r  <= cell_r[0];
        run_cnt_r  <= run_cnt_nxt;
        best_cnt_r <= best_cnt_nxt;
        best_val_r <= best_val_nxt;
        res_r      <= best_val_nxt;
      end
      S_DIV: begin
        mag_r <= SUM_W'(quot_prod[RECIP_SH +: SAMPLE_W]);
      end
      S_NEG: begin
        res_r <= neg_r ? -$signed(mag_r[SAMPLE_W-1:0]) : $signed(mag_r[SAMPLE_W-1:0]);
      end
      default: begin
      end
    endcase
    if (in_acc && !in_range) begin
      res_r <= '0;
    end
    if (state_r == S_OUT && out_free) begin
      out_d_r <= TDATA_W'({res_r, ch_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_MEDIAN;
      primed_r     <= '0;
      fv_r         <= '0;
      feed_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      k_r          <= '0;
      primed_now_r <= 1'b0;
      slot_r       <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        oldest_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      feed_v_r <= (state_r == S_RUN);
      if (feed_v_r) begin
        fv_r <= {fv_r[WINDOW-2:0], 1'b1};
      end
      if (out_v_r && out_tready && state_r != S_OUT) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            k_r  <= '0;
            fv_r <= '0;
            if (in_range) begin
              primed_now_r     <= primed_r[in_idx];
              slot_r           <= primed_r[in_idx] ? oldest_r[in_idx] : '0;
              primed_r[in_idx] <= 1'b1;
              if (!primed_r[in_idx]) begin
                oldest_r[in_idx] <= '0;
              end else if (oldest_r[in_idx] >= KW'(WINDOW - 1)) begin
                oldest_r[in_idx] <= '0;
              end else begin
                oldest_r[in_idx] <= oldest_r[in_idx] + KW'(1);
              end
              state_r <= S_RUN;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_RUN: begin
          if (k_r == KW'(WINDOW - 1)) begin
            state_r <= S_WAIT;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_WAIT: begin
          state_r <= S_SEL;
        end
        S_SEL: begin
          k_r <= '0;
          if (mode_r == MODE_MEAN) begin
            state_r <= S_DIV;
          end else if (mode_r == MODE_MODE) begin
            state_r <= S_MODE;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_MODE: begin
          if (k_r == KW'(WINDOW - 1)) begin
            state_r <= S_OUT;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_DIV: begin
          state_r <= S_NEG;
        end
        S_NEG: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_v_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  a_bad_channel_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_range) |=> (state_r == S_OUT))
    else $error("out-of-range channel did not go straight to output");

  a_feed_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    feed_v_r |-> (state_r == S_WAIT || state_r == S_RUN))
    else $error("sorter fed outside the window sweep");

  a_sorter_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEL) |-> (&fv_r))
    else $error("sorter not full when the result is selected");
endmodule

@@ tb/tb_sliding_window_median_mean_mode_filter_top.sv @@
module tb_sliding_window_median_mean_mode_filter_top;
  import swmf_pkg::*;

  localparam int NWIN = WINDOW_DEF;
  localparam int NCH  = CHANNELS_DEF;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] val;
    logic [3:0]  chan;
  } filt_beat_t;

  typedef struct {
    logic        set_mode;
    mode_t       mode;
    logic [3:0]  chan;
    logic [15:0] smp;
    logic        has_exp;
    logic [15:0] exp_val;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [TDATA_W-1:0] out_tdata;

  sliding_window_median_mean_mode_filter_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state
  logic signed [15:0] win_mem [NCH][NWIN];
  int    next_slot [NCH];
  bit    primed [NCH];
  mode_t cur_mode;

  filt_beat_t expected_q[$];
  int  errors;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_off;
  bit  stim_done;
  longint cycles;

  function automatic logic [15:0] window_result(int ch);
    int s [NWIN];
    int x, j, sum, cnt, best, best_cnt;
    for (int i = 0; i < NWIN; i++) begin
      x = win_mem[ch][i];
      j = i;
      while (j > 0 && s[j-1] > x) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = x;
    end
    if (cur_mode == MODE_MEAN) begin
      sum = 0;
      for (int i = 0; i < NWIN; i++) sum += s[i];
      return 16'(sum / NWIN);
    end else if (cur_mode == MODE_MODE) begin
      best = s[0];
      best_cnt = 0;
      for (int i = 0; i < NWIN; i++) begin
        cnt = 0;
        for (int k = 0; k < NWIN; k++) if (s[k] == s[i]) cnt++;
        if (cnt > best_cnt || (cnt == best_cnt && s[i] < best)) begin
          best = s[i];
          best_cnt = cnt;
        end
      end
      return 16'(best);
    end
    return 16'(s[NWIN/2]);
  endfunction

  function automatic filt_beat_t predict_filtered(logic [3:0] ch, logic [15:0] smp);
    filt_beat_t r;
    r.chan = ch;
    r.val  = '0;
    if (ch < NCH) begin
      if (!primed[ch]) begin
        for (int i = 0; i < NWIN; i++) win_mem[ch][i] = smp;
        primed[ch] = 1;
        next_slot[ch] = 0;
      end else begin
        win_mem[ch][next_slot[ch]] = smp;
        next_slot[ch] = (next_slot[ch] + 1) % NWIN;
      end
      r.val = window_result(ch);
    end
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    filt_beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = filt_beat_t'(out_tdata[19:0]);
      if (expected_q.size() == 0) begin
        $display("%0t unexpected beat: got ch=%0d val=%0d", $time, got.chan,
                 $signed(got.val));
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.chan !== want.chan) begin
          $display("%0t channel mismatch: expected %0d actual %0d", $time, want.chan,
                   got.chan);
          errors++;
        end
        if (got.val !== want.val) begin
          $display("%0t filtered mismatch ch=%0d: expected %0d actual %0d", $time,
                   want.chan, $signed(want.val), $signed(got.val));
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(mode_t m);
    wait_drained();
    cfg_we    <= 1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 0;
    cur_mode   = (m == 2'd3) ? MODE_MEDIAN : m;
  endtask

  task automatic send_sample(logic [3:0] ch, logic [15:0] smp, bit check_val,
                             logic [15:0] exp_val);
    filt_beat_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {4'b0, smp, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_filtered(ch, smp);
    if (check_val && p.val !== exp_val) begin
      $display("%0t table row ch=%0d: expected %0d predicted %0d", $time, ch,
               $signed(exp_val), $signed(p.val));
      errors++;
    end
    expected_q = {expected_q, p};
  endtask

  function automatic logic [15:0] rand_sample(int ch);
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(6)) - 3);
      3: return (ch < NCH && primed[ch]) ? win_mem[ch][$urandom_range(NWIN-1)]
                                         : 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t dir_rows[$];

  task automatic run_random(int n);
    int ch, m;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 59) begin
        m = $urandom_range(3);
        write_mode(mode_t'(m));
      end
      ch = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(NCH-1);
      send_sample(4'(ch), rand_sample(ch), 0, '0);
    end
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_wdata = '0; in_tvalid = 0; in_tdata = '0;
    hold_off = 0; errors = 0; cycles = 0; stim_done = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    cur_mode = MODE_MEDIAN;
    for (int c = 0; c < NCH; c++) begin
      primed[c] = 0;
      next_slot[c] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: priming, extremes, out-of-range channels, every mode
    dir_rows = '{
      '{0, MODE_MEDIAN, 4'd0, 16'h7fff, 1, 16'h7fff},
      '{0, MODE_MEDIAN, 4'd9, 16'h8000, 1, 16'h8000},
      '{0, MODE_MEDIAN, 4'd10, 16'h1234, 1, 16'h0000},
      '{0, MODE_MEDIAN, 4'd15, 16'hffff, 1, 16'h0000},
      '{0, MODE_MEDIAN, 4'd0, 16'h8000, 0, 16'h0},
      '{0, MODE_MEDIAN, 4'd0, 16'h0005, 0, 16'h0},
      '{1, MODE_MEAN, 4'd9, 16'h7fff, 0, 16'h0},
      '{0, MODE_MEAN, 4'd9, 16'h7fff, 0, 16'h0},
      '{0, MODE_MEAN, 4'd1, 16'hfff1, 1, 16'hfff1},
      '{0, MODE_MEAN, 4'd1, 16'h0003, 0, 16'h0},
      '{0, MODE_MEAN, 4'd12, 16'h0001, 1, 16'h0000},
      '{1, MODE_MODE, 4'd2, 16'h0004, 1, 16'h0004},
      '{0, MODE_MODE, 4'd2, 16'hfffe, 0, 16'h0},
      '{0, MODE_MODE, 4'd2, 16'hfffe, 0, 16'h0},
      '{0, MODE_MODE, 4'd0, 16'h0005, 0, 16'h0},
      '{1, 2'd3, 4'd2, 16'h8000, 0, 16'h0},
      '{0, 2'd3, 4'd0, 16'h7fff, 0, 16'h0},
      '{1, MODE_MEDIAN, 4'd3, 16'haaaa, 1, 16'haaaa},
      '{0, MODE_MEDIAN, 4'd3, 16'h5555, 0, 16'h0}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_mode) write_mode(dir_rows[i].mode);
      send_sample(dir_rows[i].chan, dir_rows[i].smp, dir_rows[i].has_exp,
                  dir_rows[i].exp_val);
    end

    // receiver holds off while the sender keeps offering beats
    wait_drained();
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      run_random(6);
    join

    send_idle_pct = 34; recv_idle_pct = 87;
    run_random(270);
    wait_drained();
    send_idle_pct = 87; recv_idle_pct = 34;
    run_random(270);
    send_idle_pct = 0; recv_idle_pct = 0;
    run_random(250);

    wait_drained();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_ram.sv
hw/rtl/sliding_window_median_mean_mode_filter_top.sv
tb/tb_sliding_window_median_mean_mode_filter_top.sv
